@@ rtl/ctip_pkg.sv @@
`timescale 1ns / 1ps

package ctip_pkg;

  // command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam int VAL_W     = 24;          // Q7.16 coefficient
  localparam int ANG_W     = 20;          // Q3.16 angle
  localparam int SLOT_W    = 6;
  localparam int DEG_W     = 25;          // degrees Q.16, positive angles only
  localparam int DEG_INT_W = DEG_W - 16;
  localparam int REM_W     = 22;          // offset inside a segment, Q.16 degrees
  localparam int T_W       = 17;          // t, Q0.16 up to and including 1.0
  localparam int A_W       = 28;
  localparam int B_W       = 29;
  localparam int C_W       = 25;
  localparam int H1_W      = 46;
  localparam int H3_W      = 47;
  localparam int H4_W      = 63;
  localparam int R_W       = 31;

  // 180/pi in Q.24
  localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;

  localparam logic signed [R_W-1:0] OUT_MAX = 31'sd8388607;
  localparam logic signed [R_W-1:0] OUT_MIN = -31'sd8388608;

  // segment offset and the four neighbours, as handed to the cubic pipe
  typedef struct packed {
    logic                    valid;
    logic [REM_W-1:0]        rem;
    logic signed [VAL_W-1:0] y0;
    logic signed [VAL_W-1:0] y1;
    logic signed [VAL_W-1:0] y2;
    logic signed [VAL_W-1:0] y3;
  } ctip_front_t;

endpackage

@@ rtl/ctip_ram.sv @@
`timescale 1ns / 1ps

module ctip_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/ctip_front.sv @@
`timescale 1ns / 1ps

module ctip_front import ctip_pkg::*; #(
  parameter int TABLE_ENTRIES = 10,
  parameter int STEP_DEGREES  = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_command,
  input  logic [SLOT_W-1:0]       in_entry_index,
  input  logic signed [VAL_W-1:0] in_entry_value,
  input  logic signed [ANG_W-1:0] in_angle_rad,
  input  logic                    down_ready,
  output ctip_front_t             fr
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [31:0] STEP_Q16 = 32'(STEP_DEGREES * 65536);
  localparam logic [31:0] SPAN_Q16 = 32'((TABLE_ENTRIES - 1) * STEP_DEGREES * 65536);
  // ceil(2^16 / step): exact quotient for every integer degree below 2^9
  localparam logic [16:0] IDX_RECIP = 17'((65536 + STEP_DEGREES - 1) / STEP_DEGREES);

  logic en_a, en_b, en_c, en_d;

  logic                    va_r, vb_r, vc_r, vd_r;
  logic                    cmd_a_r, cmd_b_r, cmd_c_r;
  logic [SLOT_W-1:0]       slot_a_r, slot_b_r, slot_c_r;
  logic signed [VAL_W-1:0] value_a_r, value_b_r, value_c_r;
  logic signed [ANG_W-1:0] angle_a_r;
  logic [DEG_W-1:0]        deg_b_r, deg_c_r;
  logic [DEG_INT_W-1:0]    quot_c_r;
  logic [REM_W-1:0]        rem_d_r;

  logic [DEG_W-1:0]     deg_nxt, degc_nxt;
  logic [DEG_INT_W-1:0] quot_nxt;
  logic [REM_W-1:0]     rem_nxt;
  logic [48:0]          dprod, dsum;
  logic [25:0]          qprod;
  logic [AW-1:0]        idx;
  logic [AW:0]          idx_p2;
  logic [31:0]          seg_base, rem_full;
  logic                 tbl_we;
  logic [AW-1:0]        rd_addr [4];
  logic [VAL_W-1:0]     rd_data [4];

  // a stage loads when it is empty or its content moves on
  assign en_d     = !vd_r || down_ready;
  assign en_c     = !vc_r || en_d;
  assign en_b     = !vb_r || en_c;
  assign en_a     = !va_r || en_b;
  assign in_stall = !en_a;

  // stage B: radians to degrees, negative angles give zero
  assign dprod   = 49'(angle_a_r[ANG_W-2:0]) * 49'(DEG_PER_RAD_Q24);
  assign dsum    = dprod + 49'd8388608;
  assign deg_nxt = (!angle_a_r[ANG_W-1]) ? dsum[24 +: DEG_W] : '0;

  // stage C: clamp to the span, integer quotient by the step
  assign degc_nxt = (32'(deg_b_r) > SPAN_Q16) ? SPAN_Q16[DEG_W-1:0] : deg_b_r;
  assign qprod    = 26'(degc_nxt[DEG_W-1:16]) * 26'(IDX_RECIP);
  assign quot_nxt = qprod[16 +: DEG_INT_W];

  // stage D: segment index, neighbour addresses, table write
  assign idx      = (quot_c_r > DEG_INT_W'(TABLE_ENTRIES - 2)) ?
                    AW'(TABLE_ENTRIES - 2) : quot_c_r[AW-1:0];
  assign idx_p2   = {1'b0, idx} + (AW+1)'(2);
  assign seg_base = 32'(idx) * STEP_Q16;
  assign rem_full = 32'(deg_c_r) - seg_base;
  assign rem_nxt  = rem_full[REM_W-1:0];

  assign rd_addr[0] = (idx == '0) ? '0 : idx - AW'(1);
  assign rd_addr[1] = idx;
  assign rd_addr[2] = idx + AW'(1);
  assign rd_addr[3] = (idx_p2 < (AW+1)'(TABLE_ENTRIES)) ? idx_p2[AW-1:0] :
                      AW'(TABLE_ENTRIES - 1);

  assign tbl_we = en_d && vc_r && (cmd_c_r == CMD_WRITE) &&
                  ((SLOT_W+1)'(slot_c_r) < (SLOT_W+1)'(TABLE_ENTRIES));

  // one copy of the table per neighbour, all written alike
  for (genvar g = 0; g < 4; g++) begin : g_tbl
    ctip_ram #(
      .WIDTH (VAL_W),
      .DEPTH (TABLE_ENTRIES)
    ) u_ram (
      .clk   (clk),
      .we    (tbl_we),
      .waddr (slot_c_r[AW-1:0]),
      .wdata (value_c_r),
      .re    (en_d),
      .raddr (rd_addr[g]),
      .rdata (rd_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_valid;
      if (en_b) vb_r <= va_r;
      if (en_c) vc_r <= vb_r;
      // writes end here; only lookups go on
      if (en_d) vd_r <= vc_r && (cmd_c_r == CMD_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      cmd_a_r   <= in_command;
      slot_a_r  <= in_entry_index;
      value_a_r <= in_entry_value;
      angle_a_r <= in_angle_rad;
    end
    if (en_b) begin
      cmd_b_r   <= cmd_a_r;
      slot_b_r  <= slot_a_r;
      value_b_r <= value_a_r;
      deg_b_r   <= deg_nxt;
    end
    if (en_c) begin
      cmd_c_r   <= cmd_b_r;
      slot_c_r  <= slot_b_r;
      value_c_r <= value_b_r;
      deg_c_r   <= degc_nxt;
      quot_c_r  <= quot_nxt;
    end
    if (en_d) begin
      rem_d_r <= rem_nxt;
    end
  end

  assign fr.valid = vd_r;
  assign fr.rem   = rem_d_r;
  assign fr.y0    = rd_data[0];
  assign fr.y1    = rd_data[1];
  assign fr.y2    = rd_data[2];
  assign fr.y3    = rd_data[3];

endmodule

@@ rtl/ctip_cubic.sv @@
`timescale 1ns / 1ps

module ctip_cubic import ctip_pkg::*; #(
  parameter int STEP_DEGREES = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctip_front_t             fr,
  output logic                    down_ready,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_coefficient,
  output logic                    out_saturated
);

  // ceil(2^28 / step): exact quotient for every offset below 2^22
  localparam logic [28:0] T_RECIP = 29'((2**28 + STEP_DEGREES - 1) / STEP_DEGREES);

  logic en_e, en_f, en_g, en_h, en_o;

  logic ve_r, vf_r, vg_r, vh_r, vo_r;
  logic [T_W-1:0]          t_e_r, t_f_r, t_g_r;
  logic signed [VAL_W-1:0] y1_e_r, y1_f_r, y1_g_r, y1_h_r;
  logic signed [A_W-1:0]   a_e_r;
  logic signed [B_W-1:0]   b_e_r;
  logic signed [C_W-1:0]   c_e_r, c_f_r;
  logic signed [H1_W-1:0]  h1_f_r;
  logic signed [H3_W-1:0]  h3_g_r;
  logic signed [H4_W-1:0]  h4_h_r;
  logic signed [VAL_W-1:0] coef_o_r;
  logic                    sat_o_r;

  logic [50:0]             tprod;
  logic [T_W-1:0]          t_nxt;
  logic signed [A_W-1:0]   ya0, ya1, ya2, ya3, d12, a_nxt;
  logic signed [B_W-1:0]   yb0, yb1, yb2, yb3, b_nxt;
  logic signed [C_W-1:0]   c_nxt;
  logic signed [H1_W-1:0]  ap, h1_nxt;
  logic signed [63:0]      p2, h2;
  logic signed [H3_W-1:0]  h3_nxt;
  logic signed [64:0]      p3, h4_full;
  logic signed [H4_W-1:0]  h4_nxt;
  logic signed [29:0]      h4_rnd;
  logic signed [R_W-1:0]   r_sum;
  logic signed [VAL_W-1:0] coef_nxt;
  logic                    sat_nxt;

  assign en_o       = !vo_r || !out_stall;
  assign en_h       = !vh_r || en_o;
  assign en_g       = !vg_r || en_h;
  assign en_f       = !vf_r || en_g;
  assign en_e       = !ve_r || en_f;
  assign down_ready = en_e;

  // stage E: t by reciprocal, doubled Catmull-Rom terms
  assign tprod = 51'(fr.rem) * 51'(T_RECIP);
  assign t_nxt = tprod[28 +: T_W];

  assign ya0   = A_W'(fr.y0);
  assign ya1   = A_W'(fr.y1);
  assign ya2   = A_W'(fr.y2);
  assign ya3   = A_W'(fr.y3);
  assign d12   = ya1 - ya2;
  assign a_nxt = ya3 - ya0 + (d12 <<< 1) + d12;

  assign yb0   = B_W'(fr.y0);
  assign yb1   = B_W'(fr.y1);
  assign yb2   = B_W'(fr.y2);
  assign yb3   = B_W'(fr.y3);
  assign b_nxt = (yb0 <<< 1) - (yb1 <<< 2) - yb1 + (yb2 <<< 2) - yb3;

  assign c_nxt = C_W'(fr.y2) - C_W'(fr.y0);

  // stage F: a*t + b*2^16
  assign ap     = a_e_r * $signed({1'b0, t_e_r});
  assign h1_nxt = ap + (H1_W'(b_e_r) <<< 16);

  // stage G: h1*t + c*2^32, rounded by 2^16
  assign p2     = h1_f_r * $signed({1'b0, t_f_r});
  assign h2     = p2 + (64'(c_f_r) <<< 32) + 64'sd32768;
  assign h3_nxt = h2[16 +: H3_W];

  // stage H: h3*t plus half of 2^33
  assign p3      = h3_g_r * $signed({1'b0, t_g_r});
  assign h4_full = p3 + 65'sd4294967296;
  assign h4_nxt  = h4_full[H4_W-1:0];

  // output stage: add y1, clip
  assign h4_rnd = h4_h_r[62:33];
  assign r_sum  = R_W'(h4_rnd) + R_W'(y1_h_r);

  always_comb begin
    sat_nxt  = 1'b0;
    coef_nxt = r_sum[VAL_W-1:0];
    priority if (r_sum > OUT_MAX) begin
      sat_nxt  = 1'b1;
      coef_nxt = OUT_MAX[VAL_W-1:0];
    end else if (r_sum < OUT_MIN) begin
      sat_nxt  = 1'b1;
      coef_nxt = OUT_MIN[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vg_r <= 1'b0;
      vh_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en_e) ve_r <= fr.valid;
      if (en_f) vf_r <= ve_r;
      if (en_g) vg_r <= vf_r;
      if (en_h) vh_r <= vg_r;
      if (en_o) vo_r <= vh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      t_e_r  <= t_nxt;
      a_e_r  <= a_nxt;
      b_e_r  <= b_nxt;
      c_e_r  <= c_nxt;
      y1_e_r <= fr.y1;
    end
    if (en_f) begin
      t_f_r  <= t_e_r;
      h1_f_r <= h1_nxt;
      c_f_r  <= c_e_r;
      y1_f_r <= y1_e_r;
    end
    if (en_g) begin
      t_g_r  <= t_f_r;
      h3_g_r <= h3_nxt;
      y1_g_r <= y1_f_r;
    end
    if (en_h) begin
      h4_h_r <= h4_nxt;
      y1_h_r <= y1_g_r;
    end
    if (en_o) begin
      coef_o_r <= coef_nxt;
      sat_o_r  <= sat_nxt;
    end
  end

  assign out_valid       = vo_r;
  assign out_coefficient = coef_o_r;
  assign out_saturated   = sat_o_r;

endmodule

@@ rtl/cubic_table_interpolator.sv @@
`timescale 1ns / 1ps
// Cubic table interpolator.
// Input channel (in_valid / in_stall) carries two kinds of transaction:
//   command write  - stores in_entry_value at slot in_entry_index; slots at
//                    or beyond TABLE_ENTRIES are dropped. Gives no result.
//   command lookup - in_angle_rad (Q3.16 radians) is turned into degrees,
//                    clamped to the table span and interpolated with a
//                    Catmull-Rom cubic over the four neighbouring entries.
// Result channel (out_valid / out_stall) returns one transaction per lookup:
//   out_coefficient (Q7.16, clipped) and out_saturated.
// A lookup passes front stages A to D, cubic stages E to H and the output
// stage, each registered. One transaction a cycle is taken in while
// in_stall is low; the pipeline has nine stages, of which the longest are
// the three multiplies by t. A write reaches the table as it leaves stage C,
// in pipeline order, so lookups behind it see the new value.
// Reset empties the pipeline; table contents stay undefined until written.
// When out_stall is high the held result stays put and earlier stages keep
// closing up bubbles; in_stall rises only when every stage is occupied.
module cubic_table_interpolator import ctip_pkg::*; #(
  parameter int TABLE_ENTRIES = 10,
  parameter int STEP_DEGREES  = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_command,
  input  logic [SLOT_W-1:0]       in_entry_index,
  input  logic signed [VAL_W-1:0] in_entry_value,
  input  logic signed [ANG_W-1:0] in_angle_rad,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_coefficient,
  output logic                    out_saturated
);

  ctip_front_t fr;
  logic        down_ready;

  ctip_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .STEP_DEGREES  (STEP_DEGREES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_angle_rad   (in_angle_rad),
    .down_ready     (down_ready),
    .fr             (fr)
  );

  ctip_cubic #(
    .STEP_DEGREES (STEP_DEGREES)
  ) u_cubic (
    .clk             (clk),
    .rst_n           (rst_n),
    .fr              (fr),
    .down_ready      (down_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_coefficient (out_coefficient),
    .out_saturated   (out_saturated)
  );

`ifndef ASSERT_OFF
  // input back-pressure only comes from a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // a blocked lookup in front of the cubic pipe keeps its data
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fr.valid && !down_ready) |=> (fr.valid && $stable(fr.rem) &&
                                   $stable(fr.y1) && $stable(fr.y2)))
    else $error("front stage changed while blocked");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule
